@@ hdl/bhtdr_pkg.sv @@
package bhtdr_pkg;

  localparam int MAX_BUCKETS = 4096;
  localparam int WAYS = 3;
  localparam int KEY_BITS = 16;
  localparam int AGE_BITS = 5;
  localparam int BKT_W = $clog2(MAX_BUCKETS);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NB_W = 13;

  localparam logic [8:0] DEPTH_MARGIN = 9'd4;
  localparam logic [15:0] EMPTY_RESET = 16'sd32001;
  localparam logic [NB_W-1:0] NB_RESET = NB_W'(MAX_BUCKETS);
  localparam logic [1:0] EXACT_RESET = 2'd3;

  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] REG_NUM_BUCKETS = 2'd0;
  localparam logic [1:0] REG_EXACT_BOUND = 2'd1;
  localparam logic [1:0] REG_EMPTY_SCORE = 2'd2;

  typedef struct packed {
    logic [KEY_BITS-1:0] tag;
    logic [7:0]          depth;
    logic [15:0]         move;
    logic [15:0]         score;
    logic [15:0]         eval;
    logic [1:0]          bound;
    logic                pv;
    logic [AGE_BITS-1:0] age;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic load_in;
    logic sweep_start;
    logic sweep;
    logic mul_lo;
    logic mul_hi;
    logic rd;
    logic exec;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
  } sts_t;

endpackage

@@ hdl/bucketed_hash_table_depth_replace.sv @@
// Probe and store run MUL, IDX, READ, EXEC, DONE; an unused opcode goes to DONE.
// Clear sweeps all 4096 buckets, one per cycle, before its result appears.
// A new request is accepted only in IDLE, after the previous result has left DONE.
// Reset (synchronous, active high) loads the register defaults, then runs a
// clearing pass over all 4096 buckets during which no request is accepted.
module bucketed_hash_table_depth_replace
  import bhtdr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [63:0]        hash,
  input  logic [7:0]         depth,
  input  logic [15:0]        new_move,
  input  logic signed [15:0] score,
  input  logic signed [15:0] eval,
  input  logic [1:0]         bound,
  input  logic               was_pv,
  input  logic [4:0]         age,
  input  logic               prior_hit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic [7:0]         stored_depth,
  output logic [15:0]        stored_move,
  output logic signed [15:0] stored_score,
  output logic signed [15:0] stored_eval,
  output logic [1:0]         stored_bound,
  output logic               stored_pv,
  output logic [4:0]         stored_age
);

  logic [NB_W-1:0] num_buckets;
  logic [1:0]      exact_bound_code;
  logic [15:0]     empty_score;
  logic            cfg_wr;
  cmd_t            cmd;
  sts_t            sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_buckets <= NB_RESET;
      exact_bound_code <= EXACT_RESET;
      empty_score <= EMPTY_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_NUM_BUCKETS: num_buckets <= pwdata[NB_W-1:0];
        REG_EXACT_BOUND: exact_bound_code <= pwdata[1:0];
        REG_EMPTY_SCORE: empty_score <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NUM_BUCKETS: prdata = 32'(num_buckets);
      REG_EXACT_BOUND: prdata = 32'(exact_bound_code);
      REG_EMPTY_SCORE: prdata = {{16{empty_score[15]}}, empty_score};
      default: prdata = '0;
    endcase
  end

  bhtdr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .opcode(opcode),
    .out_stall(out_stall), .sts(sts), .in_stall(in_stall),
    .out_valid(out_valid), .cmd(cmd)
  );

  bhtdr_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .num_buckets(num_buckets), .exact_bound_code(exact_bound_code),
    .empty_score(empty_score), .opcode(opcode), .hash(hash), .depth(depth),
    .new_move(new_move), .score(score), .eval(eval), .bound(bound),
    .was_pv(was_pv), .age(age), .prior_hit(prior_hit), .found(found),
    .stored_depth(stored_depth), .stored_move(stored_move),
    .stored_score(stored_score), .stored_eval(stored_eval),
    .stored_bound(stored_bound), .stored_pv(stored_pv), .stored_age(stored_age)
  );

endmodule

@@ hdl/bhtdr_ctrl.sv @@
module bhtdr_ctrl
  import bhtdr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  input  logic       out_stall,
  input  sts_t       sts,
  output logic       in_stall,
  output logic       out_valid,
  output cmd_t       cmd
);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_IDX   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_EXEC  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state, state_next;
  logic       clr_pending, clr_pending_next;
  logic       out_valid_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    state_next = state;
    clr_pending_next = clr_pending;
    unique case (state)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = clr_pending ? S_DONE : S_IDLE;
          clr_pending_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          if (opcode == OP_CLEAR) begin
            cmd.sweep_start = 1'b1;
            clr_pending_next = 1'b1;
            state_next = S_SWEEP;
          end else if (opcode == OP_PROBE || opcode == OP_STORE) begin
            state_next = S_MUL;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_MUL: begin
        cmd.mul_lo = 1'b1;
        state_next = S_IDX;
      end
      S_IDX: begin
        cmd.mul_hi = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.load_out || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      clr_pending <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      clr_pending <= clr_pending_next;
      out_valid <= out_valid_next;
    end
  end

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (state == S_DONE))
    else $error("exec not followed by done");

  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && sts.sweep_last) |=> (state != S_SWEEP))
    else $error("sweep did not end");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("pending result dropped");

  a_clear_sweeps: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_CLEAR) |=> (state == S_SWEEP))
    else $error("clear request did not start a sweep");

endmodule

@@ hdl/bhtdr_dp.sv @@
module bhtdr_dp
  import bhtdr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [NB_W-1:0]     num_buckets,
  input  logic [1:0]          exact_bound_code,
  input  logic [15:0]         empty_score,
  input  logic [1:0]          opcode,
  input  logic [63:0]         hash,
  input  logic [7:0]          depth,
  input  logic [15:0]         new_move,
  input  logic signed [15:0]  score,
  input  logic signed [15:0]  eval,
  input  logic [1:0]          bound,
  input  logic                was_pv,
  input  logic [4:0]          age,
  input  logic                prior_hit,
  output logic                found,
  output logic [7:0]          stored_depth,
  output logic [15:0]         stored_move,
  output logic signed [15:0]  stored_score,
  output logic signed [15:0]  stored_eval,
  output logic [1:0]          stored_bound,
  output logic                stored_pv,
  output logic [4:0]          stored_age
);

  row_t mem [MAX_BUCKETS];

  logic [1:0]          op_q;
  logic [63:0]         hash_q;
  logic [7:0]          depth_q;
  logic [15:0]         move_q;
  logic [15:0]         score_q;
  logic [15:0]         eval_q;
  logic [1:0]          bound_q;
  logic                pv_q;
  logic [AGE_BITS-1:0] age_q;
  logic                hit_q;

  logic [NB_W-1:0]  nb;
  logic [44:0]      p_lo;
  logic [43:0]      p_sum;
  logic [BKT_W-1:0] bucket;
  row_t             row_q;
  entry_t           fill;
  logic [BKT_W-1:0] sweep_cnt;

  logic             res_found;
  entry_t           res;

  logic [KEY_BITS-1:0] tag;
  logic [WAY_W-1:0]    probe_sel, store_sel;
  logic                probe_hit;
  logic                done;
  entry_t              cur, upd;
  row_t                new_row;
  logic                take_move, take_rest;
  logic                we;
  logic [BKT_W-1:0]    waddr;
  row_t                wdata;

  assign nb = (num_buckets > NB_W'(MAX_BUCKETS)) ? NB_W'(MAX_BUCKETS) : num_buckets;
  assign p_sum = 44'(hash_q[63:32] * nb) + 44'(p_lo[44:32]);
  assign tag = hash_q[KEY_BITS-1:0];
  assign sts.sweep_last = (sweep_cnt == BKT_W'(MAX_BUCKETS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q <= opcode;
      hash_q <= hash;
      depth_q <= depth;
      move_q <= new_move;
      score_q <= score;
      eval_q <= eval;
      bound_q <= bound;
      pv_q <= was_pv;
      age_q <= age[AGE_BITS-1:0];
      hit_q <= prior_hit;
    end
    if (cmd.mul_lo) p_lo <= hash_q[31:0] * nb;
    if (cmd.mul_hi) bucket <= p_sum[32 +: BKT_W];
  end

  // Probe: first matching way, else the last way of the bucket.
  always_comb begin
    probe_sel = WAY_W'(WAYS - 1);
    probe_hit = 1'b0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (row_q[j].tag == tag) begin
        probe_sel = WAY_W'(j);
        probe_hit = 1'b1;
      end
    end
  end

  // Store victim: matching way, else the shallowest with the lowest index on ties.
  always_comb begin
    store_sel = '0;
    done = 1'b0;
    for (int j = 0; j < WAYS; j++) begin
      if (!done) begin
        if (row_q[j].tag == tag) begin
          store_sel = WAY_W'(j);
          done = 1'b1;
        end else if (row_q[store_sel].depth > row_q[j].depth) begin
          store_sel = WAY_W'(j);
        end
      end
    end
  end

  always_comb begin
    cur = row_q[store_sel];
    take_move = (move_q != 16'd0) || !hit_q;
    take_rest = !hit_q || (bound_q == exact_bound_code) ||
                ({1'b0, depth_q} + DEPTH_MARGIN > {1'b0, cur.depth}) ||
                (age_q != cur.age);
    upd = cur;
    if (take_move) upd.move = move_q;
    if (take_rest) begin
      upd.tag = tag;
      upd.depth = depth_q;
      upd.score = score_q;
      upd.eval = eval_q;
      upd.bound = bound_q;
      upd.pv = pv_q;
      upd.age = age_q;
    end
    new_row = row_q;
    new_row[store_sel] = upd;
  end

  assign we = cmd.sweep || (cmd.exec && op_q == OP_STORE);
  assign waddr = cmd.sweep ? sweep_cnt : bucket;
  assign wdata = cmd.sweep ? {WAYS{fill}} : new_row;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) row_q <= mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      fill <= '{tag: '0, depth: '0, move: '0, score: EMPTY_RESET, eval: EMPTY_RESET,
                bound: '0, pv: 1'b0, age: '0};
    end else if (cmd.sweep_start) begin
      sweep_cnt <= '0;
      fill <= '{tag: '0, depth: '0, move: '0, score: empty_score, eval: empty_score,
                bound: '0, pv: 1'b0, age: '0};
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      res_found <= 1'b0;
      res <= '0;
    end else if (cmd.exec && op_q == OP_PROBE) begin
      res_found <= probe_hit;
      res <= row_q[probe_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found <= res_found;
      stored_depth <= res.depth;
      stored_move <= res.move;
      stored_score <= res.score;
      stored_eval <= res.eval;
      stored_bound <= res.bound;
      stored_pv <= res.pv;
      stored_age <= 5'(res.age);
    end
  end

endmodule
